// File: rtl/ifp_pkg.sv
// ----------------------------------------------------------------------------
// ifp_pkg
// shared widths, fit mode codes, pipeline structs and saturation helpers
// ----------------------------------------------------------------------------
package ifp_pkg;

    localparam int SIZE_BITS = 14;
    localparam int SIDE_W    = SIZE_BITS + 1;
    localparam int RECT_W    = SIZE_BITS + 2;
    localparam int PROD_W    = 2 * SIDE_W;
    localparam int CALC_W    = PROD_W + 2;
    localparam int EXT_W     = CALC_W - SIDE_W;
    localparam int DIV_STEPS = PROD_W;
    localparam int CFG_IDX_W = 2;
    localparam int POS_LIM   = 1 << SIDE_W;

    localparam logic signed [CALC_W-1:0] SIDE_MAX_S = CALC_W'((1 << SIDE_W) - 1);
    localparam logic signed [CALC_W-1:0] RECT_MAX_S = CALC_W'((1 << RECT_W) - 1);
    localparam logic signed [CALC_W-1:0] POS_MAX_S  = CALC_W'(POS_LIM - 1);
    localparam logic signed [CALC_W-1:0] POS_MIN_S  = CALC_W'(-POS_LIM);

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_W = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_H = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE = 2'd2;

    localparam logic [SIDE_W-1:0] SCREEN_W_RST = SIDE_W'(1920);
    localparam logic [SIDE_W-1:0] SCREEN_H_RST = SIDE_W'(1080);

    typedef enum logic [3:0] {
        MODE_NONE     = 4'd0,
        MODE_CENTRED  = 4'd1,
        MODE_TILED    = 4'd2,
        MODE_CTILED   = 4'd3,
        MODE_STRETCH  = 4'd4,
        MODE_AUTOFIT  = 4'd5,
        MODE_MAXPECT  = 4'd6,
        MODE_TMAXPECT = 4'd7,
        MODE_CROP     = 4'd8
    } t_mode;

    typedef struct packed {
        logic [SIDE_W-1:0] screen_w;
        logic [SIDE_W-1:0] screen_h;
        logic [3:0]        mode;
    } t_cfg;

    typedef struct packed {
        logic [SIDE_W-1:0] rem;
        logic [PROD_W-1:0] num;
        logic [SIDE_W-1:0] den;
    } t_lane;

    typedef struct packed {
        logic              zero;
        t_mode             mode;
        logic              sel_w;
        logic              ax_neg;
        logic              ay_neg;
        logic [SIDE_W-1:0] iw;
        logic [SIDE_W-1:0] ih;
    } t_side;

    function automatic logic signed [CALC_W-1:0] ext_side(input logic [SIDE_W-1:0] v);
        return signed'({{EXT_W{1'b0}}, v});
    endfunction

    // signed halving that truncates toward zero
    function automatic logic signed [CALC_W-1:0] half_tz(input logic signed [CALC_W-1:0] v);
        logic signed [CALC_W-1:0] t;
        t = v + CALC_W'(v[CALC_W-1]);
        return t >>> 1;
    endfunction

    function automatic logic [SIDE_W-1:0] sat_side(input logic signed [CALC_W-1:0] v);
        logic [SIDE_W-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > SIDE_MAX_S) begin
            r = '1;
        end else begin
            r = v[SIDE_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [RECT_W-1:0] sat_rect(input logic signed [CALC_W-1:0] v);
        logic [RECT_W-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > RECT_MAX_S) begin
            r = '1;
        end else begin
            r = v[RECT_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [RECT_W-1:0] sat_pos(input logic signed [CALC_W-1:0] v);
        logic signed [CALC_W-1:0] t;
        t = v;
        if (t > POS_MAX_S) begin
            t = POS_MAX_S;
        end
        if (t < POS_MIN_S) begin
            t = POS_MIN_S;
        end
        return t[RECT_W-1:0];
    endfunction

endpackage

// File: rtl/ifp_front.sv
// ----------------------------------------------------------------------------
// ifp_front
// mode decode, cross products and divider operand setup (two stages)
// ----------------------------------------------------------------------------
module ifp_front
    import ifp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  t_cfg              i_cfg,
    input  logic              i_valid,
    input  logic [SIDE_W-1:0] i_iw,
    input  logic [SIDE_W-1:0] i_ih,
    input  logic              i_present,
    output logic              o_valid,
    output t_lane             o_lane_a,
    output t_lane             o_lane_b,
    output t_side             o_side
);

    // stage one
    logic              r1_v;
    logic [SIDE_W-1:0] r1_iw, r1_ih;
    logic              r1_zero;
    t_mode             r1_mode;
    logic [PROD_W-1:0] r1_p1, r1_p2;

    logic  n1_zero;
    t_mode n1_mode;

    always_comb begin
        n1_zero = !i_present || (i_iw == '0) || (i_ih == '0) ||
                  (i_cfg.mode == MODE_NONE) || (i_cfg.mode > MODE_CROP);
        n1_mode = t_mode'(i_cfg.mode);
        if (n1_mode == MODE_AUTOFIT) begin
            n1_mode = ((i_iw <= i_cfg.screen_w) && (i_ih <= i_cfg.screen_h)) ?
                      MODE_CENTRED : MODE_MAXPECT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_iw   <= i_iw;
            r1_ih   <= i_ih;
            r1_zero <= n1_zero;
            r1_mode <= n1_mode;
            r1_p1   <= i_cfg.screen_w * i_ih;
            r1_p2   <= i_cfg.screen_h * i_iw;
        end
    end

    // stage two
    logic                     use_p2;
    logic signed [CALC_W-1:0] ax, ay;
    logic [CALC_W-1:0]        abs_ax, abs_ay;
    t_lane                    n2_a, n2_b;
    t_side                    n2_s;

    always_comb begin
        use_p2 = (r1_p1 > r1_p2) ^ (r1_mode == MODE_CROP);
        ax     = half_tz(ext_side(i_cfg.screen_w) - ext_side(r1_iw));
        ay     = half_tz(ext_side(i_cfg.screen_h) - ext_side(r1_ih));
        abs_ax = ax[CALC_W-1] ? CALC_W'(-ax) : CALC_W'(ax);
        abs_ay = ay[CALC_W-1] ? CALC_W'(-ay) : CALC_W'(ay);

        n2_a.rem = '0;
        if (r1_mode == MODE_CTILED) begin
            n2_a.num = abs_ax[PROD_W-1:0];
            n2_a.den = r1_iw;
        end else if (use_p2) begin
            n2_a.num = r1_p2;
            n2_a.den = r1_ih;
        end else begin
            n2_a.num = r1_p1;
            n2_a.den = r1_iw;
        end
        n2_b.rem = '0;
        n2_b.num = abs_ay[PROD_W-1:0];
        n2_b.den = r1_ih;

        n2_s.zero   = r1_zero;
        n2_s.mode   = r1_mode;
        n2_s.sel_w  = use_p2;
        n2_s.ax_neg = ax[CALC_W-1];
        n2_s.ay_neg = ay[CALC_W-1];
        n2_s.iw     = r1_iw;
        n2_s.ih     = r1_ih;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_lane_a <= n2_a;
            o_lane_b <= n2_b;
            o_side   <= n2_s;
        end
    end

endmodule

// File: rtl/ifp_div.sv
// ----------------------------------------------------------------------------
// ifp_div
// two-lane restoring divider, one quotient bit per register stage
// ----------------------------------------------------------------------------
module ifp_div
    import ifp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  t_lane             i_a,
    input  t_lane             i_b,
    input  t_side             i_side,
    output logic              o_valid,
    output logic [PROD_W-1:0] o_qa,
    output logic [SIDE_W-1:0] o_ra,
    output logic [SIDE_W-1:0] o_rb,
    output t_side             o_side
);

    function automatic t_lane div_step(input t_lane x);
        logic [SIDE_W:0] t;
        logic            qb;
        t_lane           y;
        t      = {x.rem, x.num[PROD_W-1]};
        qb     = (t >= {1'b0, x.den});
        y.den  = x.den;
        y.rem  = qb ? SIDE_W'(t - {1'b0, x.den}) : t[SIDE_W-1:0];
        y.num  = {x.num[PROD_W-2:0], qb};
        return y;
    endfunction

    logic  r_v [1:DIV_STEPS];
    t_lane r_a [1:DIV_STEPS];
    t_lane r_b [1:DIV_STEPS];
    t_side r_s [1:DIV_STEPS];

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_stage
        logic  v_in;
        t_lane a_in, b_in;
        t_side s_in;

        if (g == 0) begin : g_first
            assign v_in = i_valid;
            assign a_in = i_a;
            assign b_in = i_b;
            assign s_in = i_side;
        end else begin : g_next
            assign v_in = r_v[g];
            assign a_in = r_a[g];
            assign b_in = r_b[g];
            assign s_in = r_s[g];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_en) begin
                r_v[g+1] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a[g+1] <= div_step(a_in);
                r_b[g+1] <= div_step(b_in);
                r_s[g+1] <= s_in;
            end
        end
    end

    assign o_valid = r_v[DIV_STEPS];
    assign o_qa    = r_a[DIV_STEPS].num;
    assign o_ra    = r_a[DIV_STEPS].rem;
    assign o_rb    = r_b[DIV_STEPS].rem;
    assign o_side  = r_s[DIV_STEPS];

endmodule

// File: rtl/ifp_back.sv
// ----------------------------------------------------------------------------
// ifp_back
// per-mode placement, then saturation into the output register
// ----------------------------------------------------------------------------
module ifp_back
    import ifp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  t_cfg              i_cfg,
    input  logic              i_valid,
    input  t_side             i_side,
    input  logic [PROD_W-1:0] i_qa,
    input  logic [SIDE_W-1:0] i_ra,
    input  logic [SIDE_W-1:0] i_rb,
    output logic              o_valid,
    output logic [SIDE_W-1:0] o_sw,
    output logic [SIDE_W-1:0] o_sh,
    output logic [RECT_W-1:0] o_px,
    output logic [RECT_W-1:0] o_py,
    output logic [RECT_W-1:0] o_pw,
    output logic [RECT_W-1:0] o_ph,
    output logic              o_pvalid
);

    logic                     r1_v;
    logic signed [CALC_W-1:0] r1_sw, r1_sh, r1_px, r1_py, r1_pw, r1_ph;

    logic signed [CALC_W-1:0] sw_w, sh_h, iw_s, ih_s, qs, msw, msh;
    logic signed [CALC_W-1:0] modx, mody, cx, cy;
    logic signed [CALC_W-1:0] n_sw, n_sh, n_px, n_py, n_pw, n_ph;

    always_comb begin
        sw_w = ext_side(i_cfg.screen_w);
        sh_h = ext_side(i_cfg.screen_h);
        iw_s = ext_side(i_side.iw);
        ih_s = ext_side(i_side.ih);
        qs   = signed'({{(CALC_W-PROD_W){1'b0}}, i_qa});
        msw  = i_side.sel_w ? qs   : sw_w;
        msh  = i_side.sel_w ? sh_h : qs;
        modx = i_side.ax_neg ? -ext_side(i_ra) : ext_side(i_ra);
        mody = i_side.ay_neg ? -ext_side(i_rb) : ext_side(i_rb);
        cx   = modx - iw_s;
        cy   = mody - ih_s;

        n_sw = '0; n_sh = '0; n_px = '0; n_py = '0; n_pw = '0; n_ph = '0;
        case (i_side.mode)
            MODE_CENTRED: begin
                n_sw = iw_s; n_sh = ih_s;
                n_px = half_tz(sw_w - iw_s); n_py = half_tz(sh_h - ih_s);
                n_pw = iw_s; n_ph = ih_s;
            end
            MODE_TILED: begin
                n_sw = iw_s; n_sh = ih_s; n_pw = sw_w; n_ph = sh_h;
            end
            MODE_CTILED: begin
                n_sw = iw_s; n_sh = ih_s;
                n_px = cx; n_py = cy;
                n_pw = sw_w - cx; n_ph = sh_h - cy;
            end
            MODE_STRETCH: begin
                n_sw = sw_w; n_sh = sh_h; n_pw = sw_w; n_ph = sh_h;
            end
            MODE_MAXPECT: begin
                n_sw = msw; n_sh = msh;
                n_px = half_tz(sw_w - msw); n_py = half_tz(sh_h - msh);
                n_pw = msw; n_ph = msh;
            end
            MODE_TMAXPECT: begin
                n_sw = msw; n_sh = msh; n_pw = sw_w; n_ph = sh_h;
            end
            MODE_CROP: begin
                n_sw = msw; n_sh = msh;
                n_px = half_tz(sw_w - msw); n_py = half_tz(sh_h - msh);
                n_pw = sw_w; n_ph = sh_h;
            end
            default: begin
                n_sw = '0;
            end
        endcase
        if (i_side.zero) begin
            n_sw = '0; n_sh = '0; n_px = '0; n_py = '0; n_pw = '0; n_ph = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sw <= n_sw; r1_sh <= n_sh;
            r1_px <= n_px; r1_py <= n_py;
            r1_pw <= n_pw; r1_ph <= n_ph;
        end
    end

    // output register
    logic rect_ok;
    assign rect_ok = (r1_pw > 0) && (r1_ph > 0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sw     <= sat_side(r1_sw);
            o_sh     <= sat_side(r1_sh);
            o_px     <= rect_ok ? sat_pos(r1_px)  : '0;
            o_py     <= rect_ok ? sat_pos(r1_py)  : '0;
            o_pw     <= rect_ok ? sat_rect(r1_pw) : '0;
            o_ph     <= rect_ok ? sat_rect(r1_ph) : '0;
            o_pvalid <= rect_ok;
        end
    end

endmodule

// File: rtl/image_fit_placement.sv
// ----------------------------------------------------------------------------
// image_fit_placement
// scaled size and placement rectangle of an image on the screen, nine fit modes
// ----------------------------------------------------------------------------
// an input transfer passes the setup, divider and output stages to the result
// throughput: one item per cycle if not stalled; one divider register per quotient bit
// a stall on the result side holds the whole pipeline, nothing is dropped
// reset (synchronous, active low) clears all valid bits and sets screen 1920x1080,
// fit mode none
module image_fit_placement
    import ifp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SIDE_W-1:0]    i_cfg_data,
    // input stream
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [31:0]          i_s_tdata,  // image_width[14:0], image_height[29:15], zero
    input  logic                 i_s_tuser,  // image_present
    // result stream
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [95:0]          o_m_tdata,  // scaled_width, scaled_height, place_x,
                                             // place_y, place_width, place_height, zero
    output logic                 o_m_tuser   // place_valid
);

    // configuration registers
    logic [SIDE_W-1:0] r_screen_w, r_screen_h;
    logic [3:0]        r_fit_mode;
    t_cfg              cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_w <= SCREEN_W_RST;
            r_screen_h <= SCREEN_H_RST;
            r_fit_mode <= MODE_NONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SCREEN_W: r_screen_w <= i_cfg_data;
                CFG_SCREEN_H: r_screen_h <= i_cfg_data;
                CFG_FIT_MODE: r_fit_mode <= i_cfg_data[3:0];
                default:      r_fit_mode <= r_fit_mode;
            endcase
        end
    end

    assign cfg.screen_w = r_screen_w;
    assign cfg.screen_h = r_screen_h;
    assign cfg.mode     = r_fit_mode;

    // pipeline advances whenever the output register is empty or being drained
    logic en;
    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    logic  f_valid;
    t_lane f_a, f_b;
    t_side f_s;

    ifp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_cfg     (cfg),
        .i_valid   (i_s_tvalid),
        .i_iw      (i_s_tdata[SIDE_W-1:0]),
        .i_ih      (i_s_tdata[2*SIDE_W-1:SIDE_W]),
        .i_present (i_s_tuser),
        .o_valid   (f_valid),
        .o_lane_a  (f_a),
        .o_lane_b  (f_b),
        .o_side    (f_s)
    );

    logic              d_valid;
    logic [PROD_W-1:0] d_qa;
    logic [SIDE_W-1:0] d_ra, d_rb;
    t_side             d_s;

    ifp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_a     (f_a),
        .i_b     (f_b),
        .i_side  (f_s),
        .o_valid (d_valid),
        .o_qa    (d_qa),
        .o_ra    (d_ra),
        .o_rb    (d_rb),
        .o_side  (d_s)
    );

    logic [SIDE_W-1:0] sw, sh;
    logic [RECT_W-1:0] px, py, pw, ph;

    ifp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_cfg    (cfg),
        .i_valid  (d_valid),
        .i_side   (d_s),
        .i_qa     (d_qa),
        .i_ra     (d_ra),
        .i_rb     (d_rb),
        .o_valid  (o_m_tvalid),
        .o_sw     (sw),
        .o_sh     (sh),
        .o_px     (px),
        .o_py     (py),
        .o_pw     (pw),
        .o_ph     (ph),
        .o_pvalid (o_m_tuser)
    );

    assign o_m_tdata = {2'b00, ph, pw, py, px, sh, sw};

endmodule
